FILE: rtl/qrp_pkg.sv
`timescale 1ns / 1ps
// Package for the quaternion point rotation unit.
// Holds the register map, fixed register widths and the pipeline control struct.
// No dependencies.
package qrp_pkg;

  // Quaternion registers are fixed at 16 bits, signed fixed point.
  localparam int QREG_BITS = 16;
  localparam int NUM_REGS = 4;
  localparam int PADDR_W = 4;
  localparam int PDATA_W = 32;

  // Scalar part resets to 1.0 (16384 with 14 fraction bits).
  localparam logic signed [QREG_BITS-1:0] QUAT_W_RESET = 16'sd16384;

  // Register index, taken from paddr[3:2].
  typedef enum logic [1:0] {
    REG_QUAT_W = 2'd0,
    REG_QUAT_X = 2'd1,
    REG_QUAT_Y = 2'd2,
    REG_QUAT_Z = 2'd3
  } qrp_reg_e;

  // Control that travels with the last pipeline stage.
  typedef struct packed {
    logic en;   // pipeline advances this cycle
    logic vld;  // word in the stage before the output register
  } qrp_ctrl_t;

endpackage

FILE: rtl/qrp_sat.sv
`timescale 1ns / 1ps
// Output stage of the quaternion point rotation unit: clamps three coordinates
// to the output width, raises the clip flag and holds the output word.
// Depends on qrp_pkg.
module qrp_sat #(
  parameter int COORD_BITS = 16,
  parameter int ACC_BITS = 24
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  qrp_pkg::qrp_ctrl_t           ctrl_i,
  input  logic signed [ACC_BITS-1:0]   acc_i [3],
  output logic                         valid_o,
  output logic signed [COORD_BITS-1:0] rot_o [3],
  output logic                         clip_o
);

  localparam logic signed [ACC_BITS-1:0] MAX_V =
    ACC_BITS'({1'b0, {(COORD_BITS-1){1'b1}}});
  localparam logic signed [ACC_BITS-1:0] MIN_V = -MAX_V - ACC_BITS'(1);

  logic signed [COORD_BITS-1:0] rot_d [3];
  logic [2:0]                   hit;
  logic                         valid_q;
  logic signed [COORD_BITS-1:0] rot_q [3];
  logic                         clip_q;

  // Clamp each coordinate and note whether it was out of range.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (acc_i[i] > MAX_V) begin
        rot_d[i] = MAX_V[COORD_BITS-1:0];
        hit[i]   = 1'b1;
      end else if (acc_i[i] < MIN_V) begin
        rot_d[i] = MIN_V[COORD_BITS-1:0];
        hit[i]   = 1'b1;
      end else begin
        rot_d[i] = acc_i[i][COORD_BITS-1:0];
        hit[i]   = 1'b0;
      end
    end
  end

  // Output valid bit.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ctrl_i.en) begin
      valid_q <= ctrl_i.vld;
    end
  end

  // Output payload.
  always_ff @(posedge clk_i) begin
    if (ctrl_i.en) begin
      rot_q  <= rot_d;
      clip_q <= |hit;
    end
  end

  assign valid_o = valid_q;
  assign rot_o   = rot_q;
  assign clip_o  = clip_q;

endmodule

FILE: rtl/quaternion_rotate_point_unit.sv
`timescale 1ns / 1ps
// Quaternion point rotation: out = p + w*t + cross(qv, t), t = 2*cross(qv, p).
// Pipeline stages from input word to output word: products, t, products, sum, clamp.
// Throughput: one word per cycle; the whole pipeline holds while the output word waits.
// Reset: valid bits clear, quaternion resets to identity (w = 1.0, x = y = z = 0).
// Depends on qrp_pkg and qrp_sat.
module quaternion_rotate_point_unit #(
  parameter int COORD_BITS = 16,
  parameter int QUAT_FRAC_BITS = 14
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // Configuration port
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [qrp_pkg::PADDR_W-1:0]    paddr,
  input  logic [qrp_pkg::PDATA_W-1:0]    pwdata,
  output logic [qrp_pkg::PDATA_W-1:0]    prdata,
  output logic                           pready,
  // Input points
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // tdata: point_x, point_y, point_z (low bits first), zero fill
  input  logic [((3*COORD_BITS+7)/8)*8-1:0] s_axis_tdata,
  // Rotated points
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // tdata: rot_x, rot_y, rot_z (low bits first), zero fill
  output logic [((3*COORD_BITS+7)/8)*8-1:0] m_axis_tdata,
  // tuser: clipped
  output logic                           m_axis_tuser
);

  localparam int QB = qrp_pkg::QREG_BITS;
  localparam int CB = COORD_BITS;
  localparam int FB = QUAT_FRAC_BITS;
  localparam int TDW = ((3*CB+7)/8)*8;
  // Widths: first products, rounding of t, t, second products, sum, final value.
  localparam int PW = QB + CB;
  localparam int RW1 = PW + 3;
  localparam int TW = RW1 - FB;
  localparam int MW = QB + TW;
  localparam int RW2 = MW + 3;
  localparam int AW = ((RW2 - FB) > CB ? (RW2 - FB) : CB) + 1;

  localparam logic signed [RW1-1:0] HALF1 = RW1'(1) << (FB-1);
  localparam logic signed [RW2-1:0] HALF2 = RW2'(1) << (FB-1);

  // Quaternion registers.
  logic signed [QB-1:0] qw_q;
  logic signed [QB-1:0] qv_q [3];
  logic                 cfg_wr;
  qrp_pkg::qrp_reg_e    reg_sel;

  // Pipeline.
  logic                 adv;
  logic [3:0]           vld_q;
  logic signed [CB-1:0] p_in [3];
  logic signed [CB-1:0] p1_q [3];
  logic signed [CB-1:0] p2_q [3];
  logic signed [CB-1:0] p3_q [3];
  logic signed [PW-1:0] pa_q [3];
  logic signed [PW-1:0] pb_q [3];
  logic signed [TW-1:0] t_q [3];
  logic signed [MW-1:0] mw_q [3];
  logic signed [MW-1:0] ma_q [3];
  logic signed [MW-1:0] mb_q [3];
  logic signed [AW-1:0] acc_q [3];
  logic signed [RW1-1:0] r1 [3];
  logic signed [RW2-1:0] r2 [3];
  logic signed [CB-1:0] rot [3];
  logic                 clip;
  qrp_pkg::qrp_ctrl_t   sat_ctrl;

  // Register writes and reads.
  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite & pready;
  assign reg_sel = qrp_pkg::qrp_reg_e'(paddr[3:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      qw_q    <= qrp_pkg::QUAT_W_RESET;
      qv_q[0] <= '0;
      qv_q[1] <= '0;
      qv_q[2] <= '0;
    end else if (cfg_wr) begin
      case (reg_sel)
        qrp_pkg::REG_QUAT_W: qw_q    <= pwdata[QB-1:0];
        qrp_pkg::REG_QUAT_X: qv_q[0] <= pwdata[QB-1:0];
        qrp_pkg::REG_QUAT_Y: qv_q[1] <= pwdata[QB-1:0];
        qrp_pkg::REG_QUAT_Z: qv_q[2] <= pwdata[QB-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      qrp_pkg::REG_QUAT_W: prdata = qrp_pkg::PDATA_W'($unsigned(qw_q));
      qrp_pkg::REG_QUAT_X: prdata = qrp_pkg::PDATA_W'($unsigned(qv_q[0]));
      qrp_pkg::REG_QUAT_Y: prdata = qrp_pkg::PDATA_W'($unsigned(qv_q[1]));
      qrp_pkg::REG_QUAT_Z: prdata = qrp_pkg::PDATA_W'($unsigned(qv_q[2]));
      default:             prdata = '0;
    endcase
  end

  // The whole pipeline moves unless the output word is held.
  assign adv           = ~m_axis_tvalid | m_axis_tready;
  assign s_axis_tready = adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[2:0], s_axis_tvalid};
    end
  end

  // One lane per axis; axis i uses components i+1 and i+2 for the cross terms.
  for (genvar i = 0; i < 3; i++) begin : g_axis
    localparam int J = (i + 1) % 3;
    localparam int K = (i + 2) % 3;

    assign p_in[i] = s_axis_tdata[i*CB +: CB];

    // Rounding of t and of the final sum, ties toward plus infinity.
    assign r1[i] = ((RW1'(pa_q[i]) - RW1'(pb_q[i])) <<< 1) + HALF1;
    assign r2[i] = RW2'(mw_q[i]) + RW2'(ma_q[i]) - RW2'(mb_q[i]) + HALF2;

    always_ff @(posedge clk_i) begin
      if (adv) begin
        // Stage 1: first cross product terms.
        p1_q[i] <= p_in[i];
        pa_q[i] <= qv_q[J] * p_in[K];
        pb_q[i] <= qv_q[K] * p_in[J];
        // Stage 2: t = 2*cross(qv, p), rounded to an integer.
        p2_q[i] <= p1_q[i];
        t_q[i]  <= TW'(r1[i] >>> FB);
        // Stage 3: scalar and second cross product terms.
        p3_q[i] <= p2_q[i];
        mw_q[i] <= qw_q * t_q[i];
        ma_q[i] <= qv_q[J] * t_q[K];
        mb_q[i] <= qv_q[K] * t_q[J];
        // Stage 4: exact sum, rounded, plus the original coordinate.
        acc_q[i] <= AW'(r2[i] >>> FB) + AW'(p3_q[i]);
      end
    end
  end

  // Stage 5: clamp and output register.
  assign sat_ctrl.en  = adv;
  assign sat_ctrl.vld = vld_q[3];

  qrp_sat #(
    .COORD_BITS (CB),
    .ACC_BITS   (AW)
  ) u_sat (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (sat_ctrl),
    .acc_i   (acc_q),
    .valid_o (m_axis_tvalid),
    .rot_o   (rot),
    .clip_o  (clip)
  );

  assign m_axis_tdata = TDW'({rot[2], rot[1], rot[0]});
  assign m_axis_tuser = clip;

  // A held output freezes every valid bit inside the pipeline.
  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv |=> $stable(vld_q))
    else $error("pipeline valid bits moved during a stall");

  // A pure scalar quaternion gives t = 0, so nothing can saturate.
  a_no_clip_identity: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && qv_q[0] == '0 && qv_q[1] == '0 && qv_q[2] == '0 |-> !m_axis_tuser)
    else $error("clip raised with a zero vector part");

  // The clip flag comes with at least one coordinate at a bound.
  a_clip_at_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |->
      rot[0] == {1'b0, {(CB-1){1'b1}}} || rot[0] == {1'b1, {(CB-1){1'b0}}} ||
      rot[1] == {1'b0, {(CB-1){1'b1}}} || rot[1] == {1'b1, {(CB-1){1'b0}}} ||
      rot[2] == {1'b0, {(CB-1){1'b1}}} || rot[2] == {1'b1, {(CB-1){1'b0}}})
    else $error("clip raised with no coordinate at a bound");

endmodule

FILE: sim/qrp_rotation_monitor.sv
`timescale 1ns / 1ps
// Monitor for the quaternion point rotation unit: watches the register port and both streams,
// keeps its own copy of the quaternion, predicts every rotated point and compares.
// Depends on qrp_pkg.
module qrp_rotation_monitor #(
  parameter int COORD_BITS = 16,
  parameter int QUAT_FRAC_BITS = 14,
  parameter int DATA_W = ((3*COORD_BITS+7)/8)*8
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [qrp_pkg::PADDR_W-1:0] paddr,
  input  logic [qrp_pkg::PDATA_W-1:0] pwdata,
  input  logic [qrp_pkg::PDATA_W-1:0] prdata,
  input  logic                        pready,
  input  logic                        s_axis_tvalid,
  input  logic                        s_axis_tready,
  // tdata: point_x, point_y, point_z (low bits first), zero fill
  input  logic [DATA_W-1:0]           s_axis_tdata,
  input  logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  // tdata: rot_x, rot_y, rot_z (low bits first), zero fill
  input  logic [DATA_W-1:0]           m_axis_tdata,
  // tuser: clipped
  input  logic                        m_axis_tuser,
  output int                          mismatch_count_o,
  output int                          points_in_flight_o
);

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic signed [qrp_pkg::QREG_BITS-1:0] qval_t;

  typedef struct {
    coord_t x;
    coord_t y;
    coord_t z;
    logic   clipped;
  } rot_point_t;

  qval_t      quat_q [qrp_pkg::NUM_REGS];
  rot_point_t rotated_pts_q [$];
  int         words_out;

  // Round to nearest with ties toward +infinity, dropping the quaternion fraction bits.
  function automatic longint round_frac(input longint v);
    return (v + (longint'(1) <<< (QUAT_FRAC_BITS-1))) >>> QUAT_FRAC_BITS;
  endfunction

  // Clamp to the signed coordinate range and note whether clamping took place.
  function automatic coord_t clamp_coord(input longint v, inout logic clip);
    longint hi;
    longint lo;
    hi = (longint'(1) <<< (COORD_BITS-1)) - 1;
    lo = -hi - 1;
    if (v > hi) begin
      clip = 1'b1;
      return coord_t'(hi);
    end
    if (v < lo) begin
      clip = 1'b1;
      return coord_t'(lo);
    end
    return coord_t'(v);
  endfunction

  // t = 2*cross(qv, p), out = p + w*t + cross(qv, t), rounded twice, clamped at the end.
  function automatic rot_point_t rotate_point(input coord_t px, input coord_t py,
                                              input coord_t pz);
    longint qw, qx, qy, qz, x, y, z, tx, ty, tz;
    rot_point_t r;
    logic clip;
    qw = longint'(quat_q[qrp_pkg::REG_QUAT_W]);
    qx = longint'(quat_q[qrp_pkg::REG_QUAT_X]);
    qy = longint'(quat_q[qrp_pkg::REG_QUAT_Y]);
    qz = longint'(quat_q[qrp_pkg::REG_QUAT_Z]);
    x = longint'(px);
    y = longint'(py);
    z = longint'(pz);
    clip = 1'b0;
    tx = round_frac(2 * (qy * z - qz * y));
    ty = round_frac(2 * (qz * x - qx * z));
    tz = round_frac(2 * (qx * y - qy * x));
    r.x = clamp_coord(x + round_frac(qw * tx + (qy * tz - qz * ty)), clip);
    r.y = clamp_coord(y + round_frac(qw * ty + (qz * tx - qx * tz)), clip);
    r.z = clamp_coord(z + round_frac(qw * tz + (qx * ty - qy * tx)), clip);
    r.clipped = clip;
    return r;
  endfunction

  // Count a mismatch; only the first few are described.
  task automatic note_mismatch(input string what);
    mismatch_count_o++;
    if (mismatch_count_o <= 10) $display("%t: mismatch: %s", $realtime, what);
  endtask

  // Sample both streams and the register port at every rising edge.
  always @(posedge clk_i or negedge rst_ni) begin
    rot_point_t        want;
    rot_point_t        got;
    qrp_pkg::qrp_reg_e idx;
    if (!rst_ni) begin
      quat_q[qrp_pkg::REG_QUAT_W] = qrp_pkg::QUAT_W_RESET;
      quat_q[qrp_pkg::REG_QUAT_X] = '0;
      quat_q[qrp_pkg::REG_QUAT_Y] = '0;
      quat_q[qrp_pkg::REG_QUAT_Z] = '0;
      rotated_pts_q.delete();
      mismatch_count_o = 0;
      points_in_flight_o = 0;
      words_out = 0;
    end else begin
      idx = qrp_pkg::qrp_reg_e'(paddr[3:2]);
      // Register writes and read-back.
      if (psel && penable && pready && pwrite) begin
        quat_q[idx] = qval_t'(pwdata[qrp_pkg::QREG_BITS-1:0]);
      end
      if (psel && penable && pready && !pwrite &&
          prdata[qrp_pkg::QREG_BITS-1:0] !== quat_q[idx]) begin
        note_mismatch($sformatf("register %s read %0d, expected %0d", idx.name(),
                                $signed(prdata[qrp_pkg::QREG_BITS-1:0]), quat_q[idx]));
      end
      // Each accepted input word yields one rotated point.
      if (s_axis_tvalid && s_axis_tready) begin
        rotated_pts_q.push_back(rotate_point(s_axis_tdata[0 +: COORD_BITS],
                                             s_axis_tdata[COORD_BITS +: COORD_BITS],
                                             s_axis_tdata[2*COORD_BITS +: COORD_BITS]));
      end
      // Output words are compared in order with the oldest prediction.
      if (m_axis_tvalid && m_axis_tready) begin
        got.x = m_axis_tdata[0 +: COORD_BITS];
        got.y = m_axis_tdata[COORD_BITS +: COORD_BITS];
        got.z = m_axis_tdata[2*COORD_BITS +: COORD_BITS];
        got.clipped = m_axis_tuser;
        if (rotated_pts_q.size() == 0) begin
          note_mismatch($sformatf("output word %0d arrived with none expected", words_out));
        end else begin
          want = rotated_pts_q.pop_front();
          if (got.x !== want.x || got.y !== want.y || got.z !== want.z ||
              got.clipped !== want.clipped) begin
            note_mismatch($sformatf(
              "word %0d expected (%0d,%0d,%0d) clipped %0b, got (%0d,%0d,%0d) clipped %0b",
              words_out, want.x, want.y, want.z, want.clipped,
              got.x, got.y, got.z, got.clipped));
          end
        end
        words_out++;
      end
      points_in_flight_o = rotated_pts_q.size();
    end
  end

endmodule

FILE: sim/tb_quaternion_rotate_point_unit.sv
`timescale 1ns / 1ps
// Top of the testbench for quaternion_rotate_point_unit: drives points and quaternion writes
// under several idling patterns and gives the verdict. Depends on qrp_pkg, the unit and
// qrp_rotation_monitor.
module tb_quaternion_rotate_point_unit;

  localparam int COORD_BITS = 16;
  localparam int QUAT_FRAC_BITS = 14;
  localparam int DATA_W = ((3*COORD_BITS+7)/8)*8;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int RANDOM_PHASES = 12;
  localparam int POINTS_PER_PHASE = 100;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic signed [qrp_pkg::QREG_BITS-1:0] qval_t;
  typedef enum int {IDLE_NONE, IDLE_SRC, IDLE_SNK, IDLE_BOTH} idle_mode_e;

  logic                         clk_i;
  logic                         rst_ni;
  logic                         psel;
  logic                         penable;
  logic                         pwrite;
  logic [qrp_pkg::PADDR_W-1:0]  paddr;
  logic [qrp_pkg::PDATA_W-1:0]  pwdata;
  logic [qrp_pkg::PDATA_W-1:0]  prdata;
  logic                         pready;
  logic                         s_axis_tvalid;
  logic                         s_axis_tready;
  logic [DATA_W-1:0]            s_axis_tdata;
  logic                         m_axis_tvalid;
  logic                         m_axis_tready;
  logic [DATA_W-1:0]            m_axis_tdata;
  logic                         m_axis_tuser;

  int mismatch_count;
  int points_in_flight;
  int src_idle_pct;
  int snk_stall_pct;
  bit hold_off_req;

  quaternion_rotate_point_unit #(
    .COORD_BITS     (COORD_BITS),
    .QUAT_FRAC_BITS (QUAT_FRAC_BITS)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  qrp_rotation_monitor #(
    .COORD_BITS     (COORD_BITS),
    .QUAT_FRAC_BITS (QUAT_FRAC_BITS)
  ) u_rot_monitor (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .psel               (psel),
    .penable            (penable),
    .pwrite             (pwrite),
    .paddr              (paddr),
    .pwdata             (pwdata),
    .prdata             (prdata),
    .pready             (pready),
    .s_axis_tvalid      (s_axis_tvalid),
    .s_axis_tready      (s_axis_tready),
    .s_axis_tdata       (s_axis_tdata),
    .m_axis_tvalid      (m_axis_tvalid),
    .m_axis_tready      (m_axis_tready),
    .m_axis_tdata       (m_axis_tdata),
    .m_axis_tuser       (m_axis_tuser),
    .mismatch_count_o   (mismatch_count),
    .points_in_flight_o (points_in_flight)
  );

  // 100 MHz clock.
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Output side: random stalls, or one long hold-off that lets the pipeline fill up.
  initial begin
    m_axis_tready = 1'b0;
    @(negedge clk_i);
    forever begin
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        m_axis_tready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(negedge clk_i);
      end else begin
        m_axis_tready <= ($urandom_range(99) >= snk_stall_pct);
        @(negedge clk_i);
      end
    end
  end

  // The run ends with an error once nothing has moved for too long.
  initial begin
    int quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
          (psel && penable)) quiet_cycles = 0;
      else quiet_cycles++;
    end
    $display("TB_ERROR");
    $finish;
  end

  task automatic set_idle_mode(input idle_mode_e mode);
    src_idle_pct  = (mode == IDLE_SRC) ? 88 : (mode == IDLE_BOTH) ? 18 : 0;
    snk_stall_pct = (mode == IDLE_SNK) ? 88 : (mode == IDLE_BOTH) ? 18 : 0;
  endtask

  // One register transfer; psel stays high so that transfers can follow back to back.
  task automatic apb_xfer(input logic wr, input qrp_pkg::qrp_reg_e idx,
                          input logic [qrp_pkg::PDATA_W-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // Read back all four quaternion registers; the monitor checks the data.
  task automatic read_quat();
    for (int i = 0; i < qrp_pkg::NUM_REGS; i++) begin
      apb_xfer(1'b0, qrp_pkg::qrp_reg_e'(i), $urandom);
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    @(negedge clk_i);
  endtask

  // Write the quaternion with junk in the upper data bits, then read it back.
  task automatic load_quat(input qval_t w, input qval_t x, input qval_t y, input qval_t z);
    qval_t v [qrp_pkg::NUM_REGS];
    v[qrp_pkg::REG_QUAT_W] = w;
    v[qrp_pkg::REG_QUAT_X] = x;
    v[qrp_pkg::REG_QUAT_Y] = y;
    v[qrp_pkg::REG_QUAT_Z] = z;
    for (int i = 0; i < qrp_pkg::NUM_REGS; i++) begin
      apb_xfer(1'b1, qrp_pkg::qrp_reg_e'(i), {16'($urandom), v[i]});
    end
    read_quat();
  endtask

  // Offer one point and hold it until the unit takes it.
  task automatic send_point(input coord_t x, input coord_t y, input coord_t z);
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {z, y, x};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // Stop offering points and wait until every rotated point is out and the pipe is empty.
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (points_in_flight != 0) @(negedge clk_i);
    repeat (10) @(negedge clk_i);
  endtask

  // Full-range coordinates half the time, otherwise small ones or values at the range corners.
  function automatic coord_t rand_coord();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 50) return coord_t'($urandom);
    if (pick < 70) return coord_t'(int'($urandom_range(4000)) - 2000);
    case ($urandom_range(6))
      0: return -16'sd32768;
      1: return -16'sd32767;
      2: return -16'sd1;
      3: return 16'sd0;
      4: return 16'sd1;
      5: return 16'sd32766;
      default: return 16'sd32767;
    endcase
  endfunction

  function automatic qval_t corner_qval();
    case ($urandom_range(4))
      0: return -16'sd32768;
      1: return 16'sd32767;
      2: return 16'sd0;
      3: return 16'sd16384;
      default: return -16'sd16384;
    endcase
  endfunction

  // Unit quaternions, raw 16-bit values, or values at the corners of the register range.
  task automatic load_random_quat(input int flavor);
    real   a [qrp_pkg::NUM_REGS];
    real   norm;
    qval_t v [qrp_pkg::NUM_REGS];
    norm = 0.0;
    for (int i = 0; i < qrp_pkg::NUM_REGS; i++) begin
      a[i] = (real'(int'($urandom_range(20000))) - 10000.0) / 10000.0;
      norm = norm + a[i] * a[i];
      if (flavor == 1) v[i] = qval_t'($urandom);
      else v[i] = corner_qval();
    end
    norm = $sqrt(norm);
    if (flavor == 0) begin
      for (int i = 0; i < qrp_pkg::NUM_REGS; i++) begin
        v[i] = (norm < 0.05) ? ((i == 0) ? 16'sd16384 : 16'sd0)
                             : qval_t'($rtoi(a[i] * 16384.0 / norm));
      end
    end
    load_quat(v[qrp_pkg::REG_QUAT_W], v[qrp_pkg::REG_QUAT_X],
              v[qrp_pkg::REG_QUAT_Y], v[qrp_pkg::REG_QUAT_Z]);
  endtask

  initial begin
    rst_ni        = 1'b0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    hold_off_req  = 1'b0;
    set_idle_mode(IDLE_NONE);
    repeat (4) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Identity after reset: points pass through unchanged.
    read_quat();
    send_point(16'sd32767, 16'sd32767, 16'sd32767);
    send_point(-16'sd32768, -16'sd32768, -16'sd32768);
    send_point(16'sd0, 16'sd0, 16'sd0);
    send_point(16'sd1, -16'sd1, 16'sd0);

    // Quarter turn about z, with saturation at the range edges.
    drain();
    load_quat(16'sd11585, 16'sd0, 16'sd0, 16'sd11585);
    send_point(16'sd32767, 16'sd0, 16'sd0);
    send_point(16'sd0, -16'sd32768, 16'sd0);
    send_point(-16'sd32768, 16'sd32767, 16'sd1);
    send_point(16'sd100, 16'sd200, 16'sd300);

    // Non-unit quaternion at the negative extreme.
    drain();
    load_quat(-16'sd32768, -16'sd32768, -16'sd32768, -16'sd32768);
    send_point(16'sd32767, -16'sd32768, 16'sd32767);
    send_point(16'sd1, 16'sd1, 16'sd1);
    send_point(-16'sd1, 16'sd0, 16'sd1);

    // Non-unit quaternion at the positive extreme.
    drain();
    load_quat(16'sd32767, 16'sd32767, 16'sd32767, 16'sd32767);
    send_point(-16'sd32768, -16'sd32768, -16'sd32768);
    send_point(16'sd12345, -16'sd23456, 16'sd7);

    // A tiny y component puts the first rounding exactly on a half, both signs.
    drain();
    load_quat(16'sd16384, 16'sd0, 16'sd1, 16'sd0);
    send_point(16'sd0, 16'sd0, 16'sd4096);
    send_point(16'sd0, 16'sd0, -16'sd4096);

    // Half turn about x.
    drain();
    load_quat(16'sd0, 16'sd16384, 16'sd0, 16'sd0);
    send_point(16'sd3, -16'sd5, 16'sd7);

    // Random phases cycling through the idling patterns and quaternion flavors.
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      drain();
      set_idle_mode(idle_mode_e'(ph % 4));
      load_random_quat(ph % 3);
      if (ph == 0 || ph == 4) hold_off_req = 1'b1;
      repeat (POINTS_PER_PHASE) send_point(rand_coord(), rand_coord(), rand_coord());
    end

    drain();
    if (mismatch_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
